// ===== sv/trnq_pkg.sv =====
// Shared types and constants for the toroidal radius neighbor query unit.
package trnq_pkg;

  localparam int MAX_AGENTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int SCAN_CAP       = 64;
  localparam int IDX_W          = 6;
  localparam int COORD_W        = 16;
  localparam int WORLD_W        = 13;
  localparam int FLOCK_W        = 7;

  // Configuration register indexes
  localparam logic [1:0] REG_FLOCK_SIZE   = 2'd0;
  localparam logic [1:0] REG_WORLD_WIDTH  = 2'd1;
  localparam logic [1:0] REG_WORLD_HEIGHT = 2'd2;

  // Input kinds carried in tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] r;
  } entry_t;

  // Token that walks the distance test pipeline
  typedef struct packed {
    logic             vld;   // candidate (head) or hit (tail)
    logic             done;  // end-of-scan marker
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_SCAN,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

endpackage

// ===== sv/trnq_cell.sv =====
// One ring cell: holds a single agent entry and passes it to its neighbor on rotation.
module trnq_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  trnq_pkg::entry_t load_data,
  input  trnq_pkg::entry_t next_data,
  output trnq_pkg::entry_t data
);
  import trnq_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= next_data;
    end
  end

endmodule

// ===== sv/trnq_test.sv =====
// Three-stage toroidal distance test pipeline fed from the ring head.
module trnq_test #(
  parameter int FRAC_BITS = trnq_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  trnq_pkg::tok_t                   in_tok,
  input  logic [trnq_pkg::COORD_W-1:0]     qx,
  input  logic [trnq_pkg::COORD_W-1:0]     qy,
  input  logic [trnq_pkg::COORD_W-1:0]     ex,
  input  logic [trnq_pkg::COORD_W-1:0]     ey,
  input  logic [trnq_pkg::WORLD_W-1:0]     world_w,
  input  logic [trnq_pkg::WORLD_W-1:0]     world_h,
  input  logic [2*trnq_pkg::COORD_W-1:0]   qr2,
  output trnq_pkg::tok_t                   out_tok
);
  import trnq_pkg::*;

  localparam int FW = WORLD_W + FRAC_BITS;
  localparam int WW = ((FW > COORD_W) ? FW : COORD_W) + 1;

  function automatic logic [WW-1:0] axis_mag(input logic [COORD_W-1:0] a,
                                             input logic [COORD_W-1:0] b,
                                             input logic [WORLD_W-1:0] world);
    logic [COORD_W-1:0] diff;
    logic [WW-1:0]      d;
    logic [WW-1:0]      half;
    logic [WW-1:0]      full;
    diff = (a > b) ? (a - b) : (b - a);
    d    = WW'(diff);
    half = WW'(world[WORLD_W-1:1]) << FRAC_BITS;
    full = WW'(world) << FRAC_BITS;
    if (d > half) begin
      axis_mag = (full >= d) ? (full - d) : (d - full);
    end else begin
      axis_mag = d;
    end
  endfunction

  logic [WW-1:0]        mx;
  logic [WW-1:0]        my;

  tok_t                 s1_tok;
  logic [COORD_W-1:0]   s1_dx;
  logic [COORD_W-1:0]   s1_dy;
  logic                 s1_far;

  tok_t                 s2_tok;
  logic [2*COORD_W-1:0] s2_sx;
  logic [2*COORD_W-1:0] s2_sy;
  logic                 s2_far;

  logic [2*COORD_W:0]   sum;

  assign mx  = axis_mag(qx, ex, world_w);
  assign my  = axis_mag(qy, ey, world_h);
  assign sum = {1'b0, s2_sx} + {1'b0, s2_sy};

  // Control of the token travels with reset; payload does not need it.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tok.idx  <= in_tok.idx;
      s1_dx       <= mx[COORD_W-1:0];
      s1_dy       <= my[COORD_W-1:0];
      s1_far      <= (|mx[WW-1:COORD_W]) || (|my[WW-1:COORD_W]);
      s2_tok.idx  <= s1_tok.idx;
      s2_sx       <= s1_dx * s1_dx;
      s2_sy       <= s1_dy * s1_dy;
      s2_far      <= s1_far;
      out_tok.idx <= s2_tok.idx;
    end
    if (rst) begin
      s1_tok.vld  <= 1'b0;
      s1_tok.done <= 1'b0;
      s2_tok.vld  <= 1'b0;
      s2_tok.done <= 1'b0;
      out_tok.vld  <= 1'b0;
      out_tok.done <= 1'b0;
    end else if (adv) begin
      s1_tok.vld   <= in_tok.vld;
      s1_tok.done  <= in_tok.done;
      s2_tok.vld   <= s1_tok.vld;
      s2_tok.done  <= s1_tok.done;
      // a wrapped offset of 16 bits or more already exceeds any radius
      out_tok.vld  <= s2_tok.vld && !s2_far && (sum < {1'b0, qr2});
      out_tok.done <= s2_tok.done;
    end
  end

endmodule

// ===== sv/toroidal_radius_neighbor_query_unit.sv =====
// Top level of the toroidal radius neighbor query unit: entry ring, sequencer, result stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tuser: mode; tdata: index, pos_x, pos_y, radius
//  m_*     | out       | m_tvalid/m_tready  | tuser: found; tlast: last; tdata: neighbor index
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A write beat loads one ring cell. A query makes one full ring revolution to
// pick up the querying entry, one more revolution that streams entries past
// the single distance test pipeline, then sends one end marker through the
// three pipeline stages; a query whose index is out of range skips both
// revolutions. Reset clears the sequencer, pipeline and result stage and loads
// the register defaults; the entry ring itself stays undefined until written.
// A stalled result beat freezes ring, pipeline and a busy sequencer together.
module toroidal_radius_neighbor_query_unit #(
  parameter int MAX_AGENTS = trnq_pkg::MAX_AGENTS_DEF,
  parameter int FRAC_BITS  = trnq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         s_tuser,   // [0] mode
  input  logic [55:0]                  s_tdata,   // [5:0] agent_index, [21:6] pos_x,
                                                  // [37:22] pos_y, [53:38] sight_radius
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic                         m_tuser,   // [0] found
  output logic                         m_tlast,
  output logic [7:0]                   m_tdata,   // [5:0] neighbor_index
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [trnq_pkg::WORLD_W-1:0] cfg_data
);
  import trnq_pkg::*;

  localparam int IW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CW = (IW > FLOCK_W) ? IW : FLOCK_W;

  // configuration registers
  logic [FLOCK_W-1:0] flock_size;
  logic [WORLD_W-1:0] world_width;
  logic [WORLD_W-1:0] world_height;

  // sequencer
  state_t         state;
  state_t         state_next;
  logic [IW-1:0]  cnt;
  logic [IW-1:0]  cnt_next;
  logic           adv;
  logic           rot;
  logic           capture;
  tok_t           feed;
  tok_t           tail;

  // query context
  logic [IDX_W-1:0]     qidx;
  logic [COORD_W-1:0]   qx;
  logic [COORD_W-1:0]   qy;
  logic [COORD_W-1:0]   qr;
  logic [2*COORD_W-1:0] qr2;

  // result stage
  logic             pend_v;
  logic [IDX_W-1:0] pend_idx;

  // input unpacking
  logic [IDX_W-1:0] in_idx;
  entry_t           wr_ent;
  logic             in_go;
  logic             wr_go;
  logic             idx_ok;

  logic [CW-1:0] cnt_w;
  logic [CW-1:0] qidx_w;
  logic [CW-1:0] lim_w;
  logic          at_end;

  entry_t                ring [MAX_AGENTS];
  logic [MAX_AGENTS-1:0] wr_en;

  assign in_idx   = s_tdata[5:0];
  // x sits in the top of the packed entry, radius in the bottom
  assign wr_ent   = {s_tdata[21:6], s_tdata[37:22], s_tdata[53:38]};
  assign in_go    = s_tvalid && s_tready;
  assign wr_go    = in_go && (s_tuser == MODE_WRITE);
  assign idx_ok   = (32'(in_idx) < 32'(MAX_AGENTS));

  assign cfg_ready = 1'b1;

  // Everything downstream of the head moves only when the result register can take a beat.
  assign adv = !m_tvalid || m_tready;

  assign cnt_w  = CW'(cnt);
  assign qidx_w = CW'(qidx);
  assign lim_w  = (32'(flock_size) > 32'(SCAN_CAP)) ? CW'(SCAN_CAP) : CW'(flock_size);
  assign at_end = (cnt == IW'(MAX_AGENTS - 1));

  // ---------------------------------------------------------------- entry ring
  // Cell k takes from cell k+1, so the head (cell 0) shows entry cnt.
  genvar k;
  for (k = 0; k < MAX_AGENTS; k++) begin : g_cell
    assign wr_en[k] = wr_go && (CW'(in_idx) == CW'(k));
    trnq_cell u_cell (
      .clk       (clk),
      .shift     (rot),
      .load      (wr_en[k]),
      .load_data (wr_ent),
      .next_data (ring[(k + 1) % MAX_AGENTS]),
      .data      (ring[k])
    );
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      flock_size   <= FLOCK_W'(64);
      world_width  <= WORLD_W'(800);
      world_height <= WORLD_W'(600);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FLOCK_SIZE:   flock_size   <= cfg_data[FLOCK_W-1:0];
        REG_WORLD_WIDTH:  world_width  <= cfg_data;
        REG_WORLD_HEIGHT: world_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_go && (s_tuser == MODE_QUERY)) begin
          state_next = idx_ok ? ST_SEEK : ST_FLUSH;
        end
      end
      ST_SEEK: begin
        if (adv) begin
          cnt_next = at_end ? '0 : cnt + 1'b1;
          if (at_end) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          cnt_next = at_end ? '0 : cnt + 1'b1;
          if (at_end) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (adv && tail.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    rot       = 1'b0;
    capture   = 1'b0;
    feed.vld  = 1'b0;
    feed.done = 1'b0;
    feed.idx  = cnt_w[IDX_W-1:0];
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_SEEK: begin
        rot     = adv;
        capture = adv && (cnt_w == qidx_w);
      end
      ST_SCAN: begin
        rot      = adv;
        // skip the querying agent and everything past the flock
        feed.vld = (cnt_w < lim_w) && (cnt_w != qidx_w);
      end
      ST_FLUSH: feed.done = 1'b1;
      ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Hold the query index; pick up the querying entry as it passes the head.
  always_ff @(posedge clk) begin
    if (in_go) begin
      qidx <= in_idx;
    end
    if (capture) begin
      qx <= ring[0].x;
      qy <= ring[0].y;
      qr <= ring[0].r;
    end
    qr2 <= qr * qr;
  end

  // ---------------------------------------------------------------- test pipeline
  trnq_test #(
    .FRAC_BITS (FRAC_BITS)
  ) u_test (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_tok  (feed),
    .qx      (qx),
    .qy      (qy),
    .ex      (ring[0].x),
    .ey      (ring[0].y),
    .world_w (world_width),
    .world_h (world_height),
    .qr2     (qr2),
    .out_tok (tail)
  );

  // ---------------------------------------------------------------- result stage
  // Hold each hit back one step so that the final one can carry tlast.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend_v   <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b0;
      if (tail.vld) begin
        m_tvalid <= pend_v;
        pend_v   <= 1'b1;
      end else if (tail.done) begin
        m_tvalid <= 1'b1;
        pend_v   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tail.vld) begin
        m_tdata  <= {2'b00, pend_idx};
        m_tuser  <= 1'b1;
        m_tlast  <= 1'b0;
        pend_idx <= tail.idx;
      end else if (tail.done) begin
        // drop to the empty result when the scan found nothing
        m_tdata <= pend_v ? {2'b00, pend_idx} : 8'h00;
        m_tuser <= pend_v;
        m_tlast <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_idle_no_pending : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("pending hit left over after query end");

  a_ring_home : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("entry ring not at home position while idle");

  a_done_in_drain : assert property (@(posedge clk) disable iff (rst)
    tail.done |-> (state == ST_DRAIN))
    else $error("end marker reached tail outside drain");

  a_empty_is_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == 8'h00)))
    else $error("not-found result that is not a final empty beat");

endmodule
